// File: rtl/sdr_pkg.sv
// Shared types, codes and constants of the sonar distance request/response unit.
`timescale 1ns / 1ps

package sdr_pkg;

    // Sensor command that asks for a distance reading.
    localparam logic [7:0] CMD_GET_DISTANCE = 8'h22;
    localparam logic [7:0] ANGLE_LIMIT      = 8'd180;

    // Reset values of the configuration registers.
    localparam logic [7:0] FRONT_SERVO_RESET = 8'd1;
    localparam logic [7:0] REAR_SERVO_RESET  = 8'd40;

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_SERVO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAR_SERVO  = 2'd1;

    // Request opcodes.
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RX_BYTE = 1'b1;

    // Result kinds.
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    // Measurement status codes.
    localparam logic [1:0] ST_OK               = 2'd0;
    localparam logic [1:0] ST_BAD_COMMAND      = 2'd1;
    localparam logic [1:0] ST_BAD_CHECKSUM     = 2'd2;
    localparam logic [1:0] ST_INVALID_DISTANCE = 2'd3;

    localparam logic [15:0] DISTANCE_INVALID = 16'hFFFF;

    // Position of the fourth response byte.
    localparam logic [1:0] POS_LAST = 2'd3;

    // floor(n / 180) = floor((n >> 2) * RECIP_45 >> RECIP_SHIFT) for n below 2^16.
    localparam logic [14:0] RECIP_45    = 15'd23302;
    localparam int unsigned RECIP_SHIFT = 20;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        is_meas;
        logic [7:0]  degree;
        logic [15:0] distance;
        logic [1:0]  status;
    } t_job;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] distance;
        logic [1:0]  status;
        logic [31:0] total_responses;
        logic [31:0] bad_command_responses;
        logic [31:0] bad_checksum_responses;
        logic [31:0] invalid_distance_responses;
    } t_result;

    typedef enum logic [1:0] {
        BK_TAKE,
        BK_ANGLE,
        BK_ZERO,
        BK_SUM
    } t_back_state;

endpackage

// File: rtl/sdr_if.sv
// Handshake channel interfaces for requests, results and configuration writes.
`timescale 1ns / 1ps

interface sdr_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rotation_degree;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rotation_degree, output rx_byte,
                    input ready);
    modport sink   (input valid, input op, input rotation_degree, input rx_byte,
                    output ready);
endinterface

interface sdr_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] distance;
    logic [1:0]  status;
    logic [31:0] total_responses;
    logic [31:0] bad_command_responses;
    logic [31:0] bad_checksum_responses;
    logic [31:0] invalid_distance_responses;

    modport source (output valid, output kind, output tx_byte, output last,
                    output distance, output status, output total_responses,
                    output bad_command_responses, output bad_checksum_responses,
                    output invalid_distance_responses, input ready);
    modport sink   (input valid, input kind, input tx_byte, input last,
                    input distance, input status, input total_responses,
                    input bad_command_responses, input bad_checksum_responses,
                    input invalid_distance_responses, output ready);
endinterface

interface sdr_cfg_if import sdr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sdr_front.sv
// Front end: accepts requests, collects response bytes and checks completed frames.
`timescale 1ns / 1ps

module sdr_front import sdr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdr_req_if.sink   i_req,
    input  logic      i_queue_full,
    output logic      o_push,
    output t_job      o_push_job
);

    logic [7:0] r_resp [3];
    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic       w_accept;
    logic [7:0] w_sum;
    logic [15:0] w_distance;
    logic [1:0] w_status;

    assign i_req.ready = !i_queue_full;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_sum      = r_resp[0] + r_resp[1] + r_resp[2];
    assign w_distance = {r_resp[1], r_resp[2]};

    // Command byte is checked first, then the checksum, then the distance value.
    always_comb begin
        if (r_resp[0] != CMD_GET_DISTANCE) begin
            w_status = ST_BAD_COMMAND;
        end else if (w_sum != i_req.rx_byte) begin
            w_status = ST_BAD_CHECKSUM;
        end else if (w_distance == DISTANCE_INVALID) begin
            w_status = ST_INVALID_DISTANCE;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_push              = 1'b0;
        n_pos               = r_pos;
        o_push_job.is_meas  = (i_req.op == OP_RX_BYTE);
        o_push_job.degree   = i_req.rotation_degree;
        o_push_job.distance = w_distance;
        o_push_job.status   = w_status;
        if (w_accept) begin
            if (i_req.op == OP_REQUEST) begin
                // A new request abandons any partial response.
                o_push = 1'b1;
                n_pos  = '0;
            end else if (r_pos == POS_LAST) begin
                o_push = 1'b1;
                n_pos  = '0;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.op == OP_RX_BYTE && r_pos != POS_LAST) begin
            r_resp[r_pos] <= i_req.rx_byte;
        end
    end

endmodule

// File: rtl/sdr_queue.sv
// Short first-in first-out queue of jobs between the front and back ends.
`timescale 1ns / 1ps

module sdr_queue import sdr_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_job o_head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/sdr_back.sv
// Back end: turns queued jobs into command bytes and measurement results.
`timescale 1ns / 1ps

module sdr_back import sdr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_job       i_head_job,
    output logic       o_pop,
    input  logic [7:0] i_front_servo,
    input  logic [7:0] i_rear_servo,
    sdr_rsp_if.source  o_rsp
);

    t_back_state r_state;
    t_back_state n_state;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        w_load;
    logic        w_advance;
    logic [15:0] r_num;
    logic [7:0]  r_angle;
    logic [31:0] r_total;
    logic [31:0] r_bad_cmd;
    logic [31:0] r_bad_sum;
    logic [31:0] r_invalid;
    logic [31:0] n_total;
    logic [31:0] n_bad_cmd;
    logic [31:0] n_bad_sum;
    logic [31:0] n_invalid;

    logic [7:0]  w_clamp;
    logic [7:0]  w_rev;
    logic [15:0] w_prod_front;
    logic [15:0] w_prod_rear;
    logic [16:0] w_num_sum;
    logic [28:0] w_recip_prod;
    logic [7:0]  w_angle;

    // The output register is free when empty or being taken this cycle.
    assign w_advance = !r_out_valid || o_rsp.ready;

    // Interpolation numerator front*a + rear*(180 - a), formed when a request is taken.
    assign w_clamp      = (i_head_job.degree > ANGLE_LIMIT) ? ANGLE_LIMIT : i_head_job.degree;
    assign w_rev        = ANGLE_LIMIT - w_clamp;
    assign w_prod_front = 16'(i_front_servo) * 16'(w_clamp);
    assign w_prod_rear  = 16'(i_rear_servo) * 16'(w_rev);
    assign w_num_sum    = 17'(w_prod_front) + 17'(w_prod_rear);

    // Division by 180 as a shift by two and a reciprocal multiply.
    assign w_recip_prod = 29'(r_num[15:2]) * 29'(RECIP_45);
    assign w_angle      = w_recip_prod[RECIP_SHIFT +: 8];

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_TAKE: begin
                if (w_advance && i_head_valid && !i_head_job.is_meas) begin
                    n_state = BK_ANGLE;
                end
            end
            BK_ANGLE: begin
                if (w_advance) begin
                    n_state = BK_ZERO;
                end
            end
            BK_ZERO: begin
                if (w_advance) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                if (w_advance) begin
                    n_state = BK_TAKE;
                end
            end
            default: n_state = BK_TAKE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        w_load    = 1'b0;
        n_total   = r_total + 32'd1;
        n_bad_cmd = r_bad_cmd + ((i_head_job.status == ST_BAD_COMMAND) ? 32'd1 : 32'd0);
        n_bad_sum = r_bad_sum + ((i_head_job.status == ST_BAD_CHECKSUM) ? 32'd1 : 32'd0);
        n_invalid = r_invalid + ((i_head_job.status == ST_INVALID_DISTANCE) ? 32'd1 : 32'd0);
        n_out.kind                       = KIND_TX;
        n_out.tx_byte                    = '0;
        n_out.last                       = 1'b0;
        n_out.distance                   = '0;
        n_out.status                     = ST_OK;
        n_out.total_responses            = r_total;
        n_out.bad_command_responses      = r_bad_cmd;
        n_out.bad_checksum_responses     = r_bad_sum;
        n_out.invalid_distance_responses = r_invalid;
        case (r_state)
            BK_TAKE: begin
                if (w_advance && i_head_valid) begin
                    o_pop  = 1'b1;
                    w_load = 1'b1;
                    if (i_head_job.is_meas) begin
                        n_out.kind                       = KIND_MEAS;
                        n_out.distance                   = i_head_job.distance;
                        n_out.status                     = i_head_job.status;
                        n_out.total_responses            = n_total;
                        n_out.bad_command_responses      = n_bad_cmd;
                        n_out.bad_checksum_responses     = n_bad_sum;
                        n_out.invalid_distance_responses = n_invalid;
                    end else begin
                        n_out.tx_byte = CMD_GET_DISTANCE;
                    end
                end
            end
            BK_ANGLE: begin
                w_load        = w_advance;
                n_out.tx_byte = w_angle;
            end
            BK_ZERO: begin
                w_load = w_advance;
            end
            BK_SUM: begin
                w_load        = w_advance;
                n_out.tx_byte = r_angle + CMD_GET_DISTANCE;
                n_out.last    = 1'b1;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_TAKE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_bad_cmd   <= '0;
            r_bad_sum   <= '0;
            r_invalid   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && i_head_job.is_meas) begin
                r_total   <= n_total;
                r_bad_cmd <= n_bad_cmd;
                r_bad_sum <= n_bad_sum;
                r_invalid <= n_invalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
        if (o_pop && !i_head_job.is_meas) begin
            r_num <= w_num_sum[15:0];
        end
        if (r_state == BK_ANGLE && w_advance) begin
            r_angle <= w_angle;
        end
    end

    assign o_rsp.valid                      = r_out_valid;
    assign o_rsp.kind                       = r_out.kind;
    assign o_rsp.tx_byte                    = r_out.tx_byte;
    assign o_rsp.last                       = r_out.last;
    assign o_rsp.distance                   = r_out.distance;
    assign o_rsp.status                     = r_out.status;
    assign o_rsp.total_responses            = r_out.total_responses;
    assign o_rsp.bad_command_responses      = r_out.bad_command_responses;
    assign o_rsp.bad_checksum_responses     = r_out.bad_checksum_responses;
    assign o_rsp.invalid_distance_responses = r_out.invalid_distance_responses;

endmodule

// File: rtl/sonar_distance_request_response_unit.sv
// Top level of the sonar distance request/response unit.
`timescale 1ns / 1ps

// Host side of a serial ultrasonic distance exchange. Each request is either a
// distance request (op 0) carrying a rotation angle, or one byte received from the
// sensor (op 1). A distance request produces four command results: 0x22, the angle
// mapped onto the front..rear servo range, 0, and the 8-bit sum, the last
// one flagged. Every fourth received byte completes a frame and produces one
// measurement result with distance, status and the four wrapping response counters;
// a distance request restarts byte collection. Requests are accepted one per cycle
// while the job queue (QUEUE_DEPTH entries) has room; the output sequencer drains it,
// emitting four results per distance request and one per completed frame, so that
// sequencer sets the sustained rate. Configuration writes are accepted every cycle
// and should only be issued while the unit is idle.
module sonar_distance_request_response_unit import sdr_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdr_req_if.sink    i_req,
    sdr_rsp_if.source  o_rsp,
    sdr_cfg_if.sink    i_cfg
);

    logic [7:0] r_front_servo;
    logic [7:0] r_rear_servo;
    logic       w_cfg_write;
    logic       w_push;
    t_job       w_push_job;
    logic       w_queue_full;
    logic       w_pop;
    logic       w_head_valid;
    t_job       w_head_job;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_write = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_servo <= FRONT_SERVO_RESET;
            r_rear_servo  <= REAR_SERVO_RESET;
        end else if (w_cfg_write) begin
            if (i_cfg.index == CFG_FRONT_SERVO) begin
                r_front_servo <= i_cfg.data;
            end
            if (i_cfg.index == CFG_REAR_SERVO) begin
                r_rear_servo <= i_cfg.data;
            end
        end
    end

    sdr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_queue_full (w_queue_full),
        .o_push       (w_push),
        .o_push_job   (w_push_job)
    );

    sdr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_job   (w_push_job),
        .o_full       (w_queue_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head_job   (w_head_job)
    );

    sdr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head_job    (w_head_job),
        .o_pop         (w_pop),
        .i_front_servo (r_front_servo),
        .i_rear_servo  (r_rear_servo),
        .o_rsp         (o_rsp)
    );

`ifndef NO_ASSERTIONS
    // The front end must never write into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_queue_full)
        else $error("job queue written while full");

    // The back end only takes a job that is present.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("job queue read while empty");

    // Measurement results never carry command byte fields.
    a_meas_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_MEAS) |-> (!o_rsp.last && o_rsp.tx_byte == 8'd0))
        else $error("measurement result with command byte fields set");
`endif

endmodule
